>>> hw/rtl/mma_pkg.sv
// shared constants and types for the multichannel moving average
`default_nettype none

package mma_pkg;

    // defaults for the top-level parameters
    localparam int CHANNELS_DEF   = 8;
    localparam int MAX_WINDOW_DEF = 64;

    // fixed field widths
    localparam int CH_PORT_W  = 4;
    localparam int SAMPLE_W   = 16;
    localparam int TIME_W     = 32;
    localparam int WIN_W      = 7;
    localparam int SUM_W      = 22;
    localparam int DIVIDEND_W = SUM_W + 1;

    typedef logic [SAMPLE_W-1:0]   sample_t;
    typedef logic [TIME_W-1:0]     stamp_t;
    typedef logic [WIN_W-1:0]      win_t;
    typedef logic [SUM_W-1:0]      sum_t;
    typedef logic [DIVIDEND_W-1:0] dividend_t;

endpackage

`default_nettype wire

>>> hw/rtl/mma_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module mma_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mma_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module mma_div
    import mma_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      start,
    input  wire dividend_t dividend,
    input  wire win_t      divisor,
    output logic           done,
    output dividend_t      quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    win_t             rem_reg, rem_next;
    win_t             dsr_reg, dsr_next;
    dividend_t        quo_reg, quo_next;

    logic [WIN_W:0] trial;
    logic [WIN_W:0] diff;
    logic           fits;

    always_comb begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            // shift in the next dividend bit, subtract when it fits
            rem_next = fits ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> hw/rtl/multichannel_moving_average_core.sv
// top level of the multichannel boxcar moving average
//
// usage:
//   input requests (s_valid/s_ready) carry a channel, a 16-bit sample and a
//   32-bit timestamp; every request yields exactly one result request on
//   m_valid/m_ready with the updated flag, the channel error flag, the held
//   value of the channel and the latched timestamp
//   cfg_we/cfg_wdata set window_size (0 = passthrough); a write clears all
//   sums, ring positions, held values and the latched time, and must only be
//   issued while the block is idle
// request paths, one request in flight at a time:
//   bad channel or passthrough: from accept straight to the output state
//   averaging without a ring wrap: ring read and sum states, then output
//   ring wrap: a divide state waits on the 23-step shared divider that forms the
//   rounded average (sum + window/2) / window one quotient bit per cycle
//   s_ready returns in the same cycle the result appears in the output register
// reset: synchronous active-low aresetn clears all channel state, the window
//   size and the output valid flag; ring ram contents are masked by per-channel
//   wrap flags, so no clearing pass is needed
// stall: a result waits in the output register while m_ready is low; the
//   sequencer holds in its output state until the register frees up
`default_nettype none

module multichannel_moving_average_core
    import mma_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [WIN_W-1:0]     cfg_wdata,
    // input requests
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [CH_PORT_W-1:0] s_channel,
    input  wire logic [SAMPLE_W-1:0]  s_sample,
    input  wire logic [TIME_W-1:0]    s_sample_time,
    // result requests
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_updated,
    output logic                      m_channel_error,
    output logic [SAMPLE_W-1:0]       m_average,
    output logic [TIME_W-1:0]         m_latched_time
);

    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W      = $clog2(MAX_WINDOW + 1);
    localparam int RING_DEPTH = CHANNELS * MAX_WINDOW;
    localparam int ADDR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CMP_W      = 9;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;

    // configuration and per-channel state
    win_t             win_reg, win_next;
    sum_t             sum_reg  [CHANNELS];
    sum_t             sum_next [CHANNELS];
    logic [POS_W-1:0] pos_reg  [CHANNELS];
    logic [POS_W-1:0] pos_next [CHANNELS];
    sample_t          held_reg  [CHANNELS];
    sample_t          held_next [CHANNELS];
    logic [CHANNELS-1:0] wrapped_reg, wrapped_next;   // ring slots all written
    logic             filled_reg, filled_next;        // any channel has wrapped
    stamp_t           held_time_reg, held_time_next;

    // captured request
    logic [CH_PORT_W-1:0] ch_reg, ch_next;
    sample_t              smp_reg, smp_next;
    stamp_t               ts_reg, ts_next;
    logic                 err_reg, err_next;
    logic                 upd_reg, upd_next;

    // output register
    logic    m_valid_reg, m_valid_next;
    logic    m_upd_reg, m_upd_next;
    logic    m_err_reg, m_err_next;
    sample_t m_avg_reg, m_avg_next;
    stamp_t  m_time_reg, m_time_next;

    // working signals
    win_t             win_eff;
    logic [CH_W-1:0]  s_idx;
    logic [CH_W-1:0]  ch_idx;
    logic             s_ch_ok;
    logic [POS_W-1:0] pos_inc;
    logic [ADDR_W-1:0] slot_addr;
    sample_t          ring_rdata;
    sample_t          old_smp;
    sum_t             sum_new;
    logic             ram_we;
    logic             div_start;
    logic             div_done;
    dividend_t        div_dividend;
    dividend_t        div_quotient;

    // window above the ring depth acts as the ring depth
    assign win_eff = ({1'b0, win_reg} > 8'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : win_reg;

    assign s_idx   = s_channel[CH_W-1:0];
    assign ch_idx  = ch_reg[CH_W-1:0];
    assign s_ch_ok = ({1'b0, s_channel} < 5'(CHANNELS));
    assign pos_inc = pos_reg[ch_idx] + 1'b1;

    assign slot_addr = ADDR_W'(ch_idx) * ADDR_W'(MAX_WINDOW) + ADDR_W'(pos_reg[ch_idx]);

    // unwritten slots of a channel that has not wrapped read as zero
    assign old_smp = wrapped_reg[ch_idx] ? ring_rdata : '0;
    assign sum_new = sum_reg[ch_idx] - SUM_W'(old_smp) + SUM_W'(smp_reg);

    // rounding: add half the window before dividing
    assign div_dividend = {1'b0, sum_new} + DIVIDEND_W'(win_eff >> 1);

    mma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_ring (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(slot_addr),
        .wdata(smp_reg),
        .raddr(slot_addr),
        .rdata(ring_rdata)
    );

    mma_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (win_eff),
        .done    (div_done),
        .quotient(div_quotient)
    );

    always_comb begin
        state_next     = state_reg;
        win_next       = win_reg;
        sum_next       = sum_reg;
        pos_next       = pos_reg;
        held_next      = held_reg;
        wrapped_next   = wrapped_reg;
        filled_next    = filled_reg;
        held_time_next = held_time_reg;
        ch_next        = ch_reg;
        smp_next       = smp_reg;
        ts_next        = ts_reg;
        err_next       = err_reg;
        upd_next       = upd_reg;
        m_valid_next   = m_valid_reg;
        m_upd_next     = m_upd_reg;
        m_err_next     = m_err_reg;
        m_avg_next     = m_avg_reg;
        m_time_next    = m_time_reg;
        ram_we         = 1'b0;
        div_start      = 1'b0;

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    ch_next  = s_channel;
                    smp_next = s_sample;
                    ts_next  = s_sample_time;
                    err_next = 1'b0;
                    upd_next = 1'b0;
                    if (!s_ch_ok) begin
                        // out-of-range channel, state untouched
                        err_next   = 1'b1;
                        state_next = S_OUT;
                    end else if (win_eff == '0) begin
                        // passthrough
                        held_next[s_idx] = s_sample;
                        sum_next[s_idx]  = SUM_W'(s_sample);
                        held_time_next   = s_sample_time;
                        upd_next         = 1'b1;
                        state_next       = S_OUT;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                // ring read of the oldest sample is in flight
                state_next = S_SUM;
            end
            S_SUM: begin
                sum_next[ch_idx] = sum_new;
                ram_we           = 1'b1;
                if (CMP_W'(pos_inc) == CMP_W'(win_eff)) begin
                    // ring wrap: latch time now, average after the divide
                    pos_next[ch_idx]     = '0;
                    wrapped_next[ch_idx] = 1'b1;
                    filled_next          = 1'b1;
                    held_time_next       = ts_reg;
                    upd_next             = 1'b1;
                    div_start            = 1'b1;
                    state_next           = S_DIV;
                end else begin
                    pos_next[ch_idx] = pos_inc;
                    if (!filled_reg) begin
                        // warm-up, pass the raw sample
                        held_next[ch_idx] = smp_reg;
                        held_time_next    = ts_reg;
                        upd_next          = 1'b1;
                    end
                    state_next = S_OUT;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    held_next[ch_idx] = div_quotient[SAMPLE_W-1:0];
                    state_next        = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_upd_next   = upd_reg;
                    m_err_next   = err_reg;
                    m_avg_next   = err_reg ? '0 : held_reg[ch_idx];
                    m_time_next  = held_time_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // window write clears the store; the user must issue it only while idle, the block does not enforce it
        if (cfg_we) begin
            win_next       = cfg_wdata;
            wrapped_next   = '0;
            filled_next    = 1'b0;
            held_time_next = '0;
            for (int i = 0; i < CHANNELS; i++) begin
                sum_next[i]  = '0;
                pos_next[i]  = '0;
                held_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            win_reg       <= '0;
            wrapped_reg   <= '0;
            filled_reg    <= 1'b0;
            held_time_reg <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                sum_reg[i]  <= '0;
                pos_reg[i]  <= '0;
                held_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            wrapped_reg   <= wrapped_next;
            filled_reg    <= filled_next;
            held_time_reg <= held_time_next;
            m_valid_reg   <= m_valid_next;
            sum_reg       <= sum_next;
            pos_reg       <= pos_next;
            held_reg      <= held_next;
        end
        ch_reg     <= ch_next;
        smp_reg    <= smp_next;
        ts_reg     <= ts_next;
        err_reg    <= err_next;
        upd_reg    <= upd_next;
        m_upd_reg  <= m_upd_next;
        m_err_reg  <= m_err_next;
        m_avg_reg  <= m_avg_next;
        m_time_reg <= m_time_next;
    end

    assign s_ready         = aresetn && (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_updated       = m_upd_reg;
    assign m_channel_error = m_err_reg;
    assign m_average       = m_avg_reg;
    assign m_latched_time  = m_time_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mma_checker.sv
// port-level checks for the moving average core, bound to the top level
`default_nettype none

module mma_checker
    import mma_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic                 m_updated,
    input wire logic                 m_channel_error,
    input wire logic [SAMPLE_W-1:0]  m_average,
    input wire logic [TIME_W-1:0]    m_latched_time
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_average)
            && $stable(m_latched_time) && $stable(m_updated)
            && $stable(m_channel_error))
        else $error("stalled result changed");

    // one request in flight: no accept on the cycle after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

    // a rejected channel reports no update and a zero value
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_channel_error |-> !m_updated && (m_average == '0))
        else $error("bad channel result malformed");

    // no fresh result appears while a request is still being taken
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared on the cycle after accept");

endmodule

bind multichannel_moving_average_core mma_checker u_mma_checker (.*);

`default_nettype wire
